// ----- rtl/core/round_robin_node_failover_defines.svh -----
// Assertion macros for the round-robin node failover module.
`ifndef ROUND_ROBIN_NODE_FAILOVER_DEFINES_SVH
`define ROUND_ROBIN_NODE_FAILOVER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RRNF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrnf same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RRNF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrnf next-cycle check failed");

`endif

// ----- rtl/core/rrnf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rrnf_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_GRACE      = 1'b1;

    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_MARK   = 1'b1;

    localparam logic [3:0]  NODE_COUNT_RESET = 4'd1;
    localparam logic [15:0] GRACE_RESET      = 16'd60;

    typedef struct packed {
        logic [3:0]  node_count;
        logic [15:0] grace_seconds;
    } rrnf_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CUR,
        ST_GRACE,
        ST_SCAN,
        ST_OUT
    } rrnf_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/rrnf_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rrnf_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] now_seconds;
    logic [2:0]  failed_node;

    modport source (output valid, operation, now_seconds, failed_node, input ready);
    modport sink (input valid, operation, now_seconds, failed_node, output ready);
endinterface

interface rrnf_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] chosen_node;
    logic       found;

    modport source (output valid, chosen_node, found, input ready);
    modport sink (input valid, chosen_node, found, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rrnf_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rrnf_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rrnf_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [rrnf_pkg::DATA_W-1:0]   pwdata,
    output logic      [rrnf_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output rrnf_pkg::rrnf_cfg_t                cfg
);
    import rrnf_pkg::*;

    rrnf_cfg_t cfg_reg;
    rrnf_cfg_t cfg_next;
    logic      wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_NODE_COUNT: cfg_next.node_count    = pwdata[3:0];
                REG_GRACE:      cfg_next.grace_seconds = pwdata[15:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_NODE_COUNT: prdata = {28'd0, cfg_reg.node_count};
            REG_GRACE:      prdata = {16'd0, cfg_reg.grace_seconds};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_count    <= NODE_COUNT_RESET;
            cfg_reg.grace_seconds <= GRACE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/round_robin_node_failover.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Round-robin node selector with a grace time for dead nodes.
// The req channel carries one item per request: a select (operation 0) with the
// current time, or a mark (operation 1) that records failed_node as dead at that time.
// A select gives exactly one item on the rsp channel: the chosen node and a found flag.
// A mark gives no rsp item and is taken in its accepting cycle; req.ready stays high,
// so marks may follow each other with no gap.
// A select passes ST_CUR then ST_OUT when the pointed node is alive, ST_CUR, ST_GRACE
// and ST_OUT when it is revived, and ST_SCAN after ST_GRACE when the ring is scanned
// by a sequencer that tests one node per cycle; then the result waits in the output
// register. With the receiver ready, a new select is accepted only after the last
// one's rsp item is taken.
// The death times sit in a small memory with a registered read; per-node valid bits
// mark which entries hold a death time, so no clearing pass is needed.
// req.ready is low from an accepted select until its rsp item is taken; a stalled
// receiver holds the block with the result steady on rsp. Reset makes every node
// alive, points at node 0, sets node_count to 1 and grace_seconds to 60. Registers
// are written over the APB port by the user only while idle; the block does not check.
`include "round_robin_node_failover_defines.svh"

module round_robin_node_failover #(
    parameter int NODES = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rrnf_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [rrnf_pkg::DATA_W-1:0]   pwdata,
    output logic      [rrnf_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    rrnf_req_if.sink                           req,
    rrnf_rsp_if.source                         rsp
);
    import rrnf_pkg::*;

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W = ($clog2(NODES + 1) > 4) ? $clog2(NODES + 1) : 4;

    rrnf_cfg_t   cfg;
    rrnf_state_t state_reg;
    rrnf_state_t state_next;

    logic [31:0]      mem [NODES];
    logic [31:0]      rd_q;
    logic [NODES-1:0] valid_reg;
    logic [NODES-1:0] valid_next;

    logic [CNT_W-1:0] n_reg,      n_next;
    logic [CNT_W-1:0] left_reg,   left_next;
    logic [IDX_W-1:0] cur_reg,    cur_next;
    logic [IDX_W-1:0] k_reg,      k_next;
    logic [IDX_W-1:0] ptr_reg,    ptr_next;
    logic [31:0]      now_reg,    now_next;
    logic [2:0]       chosen_reg, chosen_next;
    logic             found_reg,  found_next;

    logic             req_fire;
    logic             mark_fire;
    logic             mark_ok;
    logic [IDX_W-1:0] mark_idx;
    logic [31:0]      mark_val;
    logic [CNT_W-1:0] cnt_raw;
    logic [CNT_W-1:0] cnt_eff;
    logic             grace_over;

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] k,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] kp1;
        kp1 = CNT_W'(k) + CNT_W'(1);
        return (kp1 == n) ? '0 : IDX_W'(kp1);
    endfunction

    rrnf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = (state_reg == ST_OUT);
    assign rsp.chosen_node = chosen_reg;
    assign rsp.found       = found_reg;

    assign req_fire  = req.valid && req.ready;
    assign mark_ok   = CNT_W'(req.failed_node) < CNT_W'(NODES);
    assign mark_fire = req_fire && (req.operation == OP_MARK) && mark_ok;
    assign mark_idx  = IDX_W'(req.failed_node);
    assign mark_val  = (req.now_seconds == 32'd0) ? 32'd1 : req.now_seconds;

    assign cnt_raw = CNT_W'(cfg.node_count);
    assign cnt_eff = (cnt_raw == '0) ? CNT_W'(1)
                   : ((cnt_raw > CNT_W'(NODES)) ? CNT_W'(NODES) : cnt_raw);

    assign grace_over = ({1'b0, rd_q} + 33'(cfg.grace_seconds)) <= {1'b0, now_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.operation == OP_SELECT))
                    state_next = ST_CUR;
            end
            ST_CUR:
            begin
                state_next = valid_reg[cur_reg] ? ST_GRACE : ST_OUT;
            end
            ST_GRACE:
            begin
                state_next = grace_over ? ST_OUT : ST_SCAN;
            end
            ST_SCAN:
            begin
                if ((left_reg == '0) || !valid_reg[k_reg])
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        valid_next  = valid_reg;
        n_next      = n_reg;
        left_next   = left_reg;
        cur_next    = cur_reg;
        k_next      = k_reg;
        ptr_next    = ptr_reg;
        now_next    = now_reg;
        chosen_next = chosen_reg;
        found_next  = found_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (mark_fire)
                    valid_next[mark_idx] = 1'b1;
                if (req_fire && (req.operation == OP_SELECT))
                begin
                    n_next   = cnt_eff;
                    now_next = req.now_seconds;
                    cur_next = (CNT_W'(ptr_reg) >= cnt_eff) ? '0 : ptr_reg;
                end
            end
            ST_CUR:
            begin
                if (!valid_reg[cur_reg])
                begin
                    chosen_next = 3'(cur_reg);
                    found_next  = 1'b1;
                    ptr_next    = ring_inc(cur_reg, n_reg);
                end
            end
            ST_GRACE:
            begin
                if (grace_over)
                begin
                    valid_next[cur_reg] = 1'b0;
                    chosen_next         = 3'(cur_reg);
                    found_next          = 1'b1;
                    ptr_next            = ring_inc(cur_reg, n_reg);
                end
                else
                begin
                    k_next    = ring_inc(cur_reg, n_reg);
                    left_next = n_reg - CNT_W'(1);
                end
            end
            ST_SCAN:
            begin
                if (left_reg == '0)
                begin
                    chosen_next = '0;
                    found_next  = 1'b0;
                    ptr_next    = ring_inc(cur_reg, n_reg);
                end
                else if (!valid_reg[k_reg])
                begin
                    chosen_next = 3'(k_reg);
                    found_next  = 1'b1;
                    ptr_next    = ring_inc(k_reg, n_reg);
                end
                else
                begin
                    k_next    = ring_inc(k_reg, n_reg);
                    left_next = left_reg - CNT_W'(1);
                end
            end
            ST_OUT:
            begin
                found_next = found_reg;
            end
            default: found_next = found_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mark_fire)
            mem[mark_idx] <= mark_val;
        rd_q <= mem[cur_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        left_reg   <= left_next;
        cur_reg    <= cur_next;
        k_reg      <= k_next;
        now_reg    <= now_next;
        chosen_reg <= chosen_next;
        found_reg  <= found_next;
    end

    `RRNF_ASSERT_NOW(a_none_is_zero, rsp.valid && !rsp.found, rsp.chosen_node == 3'd0)
    `RRNF_ASSERT_NEXT(a_select_starts, req_fire && (req.operation == OP_SELECT), state_reg == ST_CUR)
    `RRNF_ASSERT_NOW(a_ptr_in_ring, state_reg == ST_OUT, CNT_W'(ptr_reg) < n_reg)
    `RRNF_ASSERT_NEXT(a_result_holds, rsp.valid && !rsp.ready, rsp.valid && $stable(ptr_reg))

endmodule

`default_nettype wire
